[rtl/core/mcsp_pkg.sv]
// Shared types, phase codes and chunk identifiers for the 3DS chunk stream parser.
`timescale 1ns / 1ps

package mcsp_pkg;

  localparam logic [4:0] NAME_MAX_BYTES = 5'd20;

  // Parse phases
  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_NAME   = 4'd1;
  localparam logic [3:0] PH_COUNT  = 4'd2;
  localparam logic [3:0] PH_VERTEX = 4'd3;
  localparam logic [3:0] PH_FACE   = 4'd4;
  localparam logic [3:0] PH_MAP    = 4'd5;
  localparam logic [3:0] PH_SKIP   = 4'd6;

  // Chunk identifiers
  localparam logic [15:0] ID_MAIN     = 16'h4d4d;
  localparam logic [15:0] ID_EDIT     = 16'h3d3d;
  localparam logic [15:0] ID_OBJECT   = 16'h4000;
  localparam logic [15:0] ID_TRIMESH  = 16'h4100;
  localparam logic [15:0] ID_VERTICES = 16'h4110;
  localparam logic [15:0] ID_FACES    = 16'h4120;
  localparam logic [15:0] ID_MAPPING  = 16'h4140;

  // Record kinds
  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_VERTEX = 3'd1;
  localparam logic [2:0] KIND_FACE   = 3'd2;
  localparam logic [2:0] KIND_MAP    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [7:0] FLOAT_EXP_ONES = 8'hff;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  hdr_cnt;
    logic [15:0] chunk_id;
    logic [31:0] chunk_size;
    logic [31:0] skip_left;
    logic [15:0] elem_total;
    logic [15:0] elem_idx;
    logic [3:0]  elem_byte;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [4:0]  name_cnt;
    logic        halted;
  } mcsp_state_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [15:0] number;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
  } mcsp_result_t;

endpackage

[rtl/core/mesh_chunk_stream_parser_core.sv]
// Top level of the 3DS chunk stream parser: byte register, parser state and result register.
`timescale 1ns / 1ps

//  channel  direction  tdata                               tuser
//  in_      slave      data_byte[7:0]                      -
//  out_     master     element_number, word_a/b/c (112b)   record_kind[2:0]
//
//  One byte beat is taken per cycle unless the byte stage is blocked; a byte
//  waits in the input register, and its record, if any, is registered into
//  the result register as the byte leaves the input register.
//  The result register blocks the byte stage only while it holds an untaken beat.
//  rst_n (synchronous) returns the parser to header parsing and clears a halt.

module mesh_chunk_stream_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [15:0] element_number, [47:16] word_a,
                                   // [79:48] word_b, [111:80] word_c
  output logic [2:0]   out_tuser   // [2:0] record_kind
);

  logic                  byte_valid_r;
  logic [7:0]            byte_r;
  mcsp_pkg::mcsp_state_t st_r;
  mcsp_pkg::mcsp_state_t st_nxt;
  mcsp_pkg::mcsp_result_t res;
  logic                  out_valid_r;
  logic [2:0]            out_kind_r;
  logic [111:0]          out_data_r;
  logic                  out_free;
  logic                  advance;

  mcsp_step u_step (
    .cur       (st_r),
    .data_byte (byte_r),
    .nxt       (st_nxt),
    .res       (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = byte_valid_r && out_free;
  assign in_tready = !byte_valid_r || out_free;

  // An all-zero state is header parsing with every counter cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '0;
    end else begin
      if (in_tready) begin
        byte_valid_r <= in_tvalid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
    if (advance && res.valid) begin
      out_kind_r <= res.kind;
      out_data_r <= {res.word_c, res.word_b, res.word_a, res.number};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

[rtl/core/mcsp_step.sv]
// Next-state and result logic of the chunk parser for one input byte.
`timescale 1ns / 1ps

module mcsp_step (
  input  mcsp_pkg::mcsp_state_t  cur,
  input  logic [7:0]             data_byte,
  output mcsp_pkg::mcsp_state_t  nxt,
  output mcsp_pkg::mcsp_result_t res
);

  logic [2:0]  hb_inc;
  logic [15:0] id_new;
  logic [31:0] size_new;
  logic [1:0]  wsel;
  logic [31:0] lane;
  logic [31:0] w0_new;
  logic [31:0] w1_new;
  logic [31:0] w2_new;
  logic [3:0]  eb_inc;
  logic [15:0] idx_inc;
  logic [4:0]  name_inc;
  logic [31:0] skip_dec;
  logic        bad_x;
  logic        bad_y;
  logic        bad_z;

  always_comb begin
    // Header assembly: bytes 0-1 are the id, 2-5 the length, little-endian.
    id_new   = (cur.hdr_cnt == 3'd0) ? 16'd0 : cur.chunk_id;
    size_new = (cur.hdr_cnt == 3'd0) ? 32'd0 : cur.chunk_size;
    case (cur.hdr_cnt)
      3'd0:    id_new[7:0]     = id_new[7:0] | data_byte;
      3'd1:    id_new[15:8]    = id_new[15:8] | data_byte;
      3'd2:    size_new[7:0]   = size_new[7:0] | data_byte;
      3'd3:    size_new[15:8]  = size_new[15:8] | data_byte;
      3'd4:    size_new[23:16] = size_new[23:16] | data_byte;
      3'd5:    size_new[31:24] = size_new[31:24] | data_byte;
      default: size_new        = size_new;
    endcase
    hb_inc = cur.hdr_cnt + 3'd1;

    // Element word assembly; the third word absorbs any later bytes.
    wsel = (cur.elem_byte[3:2] == 2'd3) ? 2'd2 : cur.elem_byte[3:2];
    lane = {24'd0, data_byte} << {cur.elem_byte[1:0], 3'b000};
    w0_new = cur.word0 | ((wsel == 2'd0) ? lane : 32'd0);
    w1_new = cur.word1 | ((wsel == 2'd1) ? lane : 32'd0);
    w2_new = cur.word2 | ((wsel == 2'd2) ? lane : 32'd0);
    eb_inc = cur.elem_byte + 4'd1;
    idx_inc  = cur.elem_idx + 16'd1;
    name_inc = cur.name_cnt + 5'd1;
    skip_dec = (cur.skip_left != 32'd0) ? cur.skip_left - 32'd1 : cur.skip_left;
    bad_x = (w0_new[30:23] == mcsp_pkg::FLOAT_EXP_ONES);
    bad_y = (w1_new[30:23] == mcsp_pkg::FLOAT_EXP_ONES);
    bad_z = (w2_new[30:23] == mcsp_pkg::FLOAT_EXP_ONES);

    nxt = cur;
    res = '0;

    if (!cur.halted) begin
      case (cur.phase)
        mcsp_pkg::PH_HEADER: begin
          nxt.chunk_id   = id_new;
          nxt.chunk_size = size_new;
          if (hb_inc < 3'd6) begin
            nxt.hdr_cnt = hb_inc;
          end else begin
            nxt.hdr_cnt = 3'd0;
            case (id_new)
              mcsp_pkg::ID_MAIN, mcsp_pkg::ID_EDIT, mcsp_pkg::ID_TRIMESH: begin
                nxt.phase = mcsp_pkg::PH_HEADER;
              end
              mcsp_pkg::ID_OBJECT: begin
                nxt.name_cnt = 5'd0;
                nxt.phase    = mcsp_pkg::PH_NAME;
              end
              mcsp_pkg::ID_VERTICES, mcsp_pkg::ID_FACES, mcsp_pkg::ID_MAPPING: begin
                nxt.elem_byte  = 4'd0;
                nxt.elem_total = 16'd0;
                nxt.phase      = mcsp_pkg::PH_COUNT;
              end
              default: begin
                if (size_new < 32'd6) begin
                  nxt.halted = 1'b1;
                  res.valid  = 1'b1;
                  res.kind   = mcsp_pkg::KIND_ERROR;
                  res.word_a = {16'd0, id_new};
                  res.word_b = size_new;
                end else begin
                  nxt.skip_left = size_new - 32'd6;
                  if (size_new != 32'd6) begin
                    nxt.phase = mcsp_pkg::PH_SKIP;
                  end
                end
              end
            endcase
          end
        end

        mcsp_pkg::PH_NAME: begin
          res.valid    = 1'b1;
          res.kind     = mcsp_pkg::KIND_NAME;
          res.number   = {11'd0, cur.name_cnt};
          res.word_a   = {24'd0, data_byte};
          nxt.name_cnt = name_inc;
          if (data_byte == 8'd0 || name_inc >= mcsp_pkg::NAME_MAX_BYTES) begin
            nxt.phase = mcsp_pkg::PH_HEADER;
          end
        end

        mcsp_pkg::PH_COUNT: begin
          if (cur.elem_byte == 4'd0) begin
            nxt.elem_total = {8'd0, data_byte};
            nxt.elem_byte  = 4'd1;
          end else begin
            nxt.elem_total = {data_byte, cur.elem_total[7:0]};
            nxt.elem_idx   = 16'd0;
            nxt.elem_byte  = 4'd0;
            nxt.word0      = 32'd0;
            nxt.word1      = 32'd0;
            nxt.word2      = 32'd0;
            if ({data_byte, cur.elem_total[7:0]} == 16'd0) begin
              nxt.phase = mcsp_pkg::PH_HEADER;
            end else if (cur.chunk_id == mcsp_pkg::ID_VERTICES) begin
              nxt.phase = mcsp_pkg::PH_VERTEX;
            end else if (cur.chunk_id == mcsp_pkg::ID_FACES) begin
              nxt.phase = mcsp_pkg::PH_FACE;
            end else begin
              nxt.phase = mcsp_pkg::PH_MAP;
            end
          end
        end

        mcsp_pkg::PH_VERTEX, mcsp_pkg::PH_FACE, mcsp_pkg::PH_MAP: begin
          nxt.word0     = w0_new;
          nxt.word1     = w1_new;
          nxt.word2     = w2_new;
          nxt.elem_byte = eb_inc;
          if ((cur.phase == mcsp_pkg::PH_VERTEX && eb_inc >= 4'd12) ||
              (cur.phase != mcsp_pkg::PH_VERTEX && eb_inc >= 4'd8)) begin
            res.valid  = 1'b1;
            res.number = cur.elem_idx;
            if (cur.phase == mcsp_pkg::PH_VERTEX) begin
              res.kind   = (bad_x || bad_y || bad_z) ? mcsp_pkg::KIND_ERROR
                                                     : mcsp_pkg::KIND_VERTEX;
              res.word_a = w0_new;
              res.word_b = w1_new;
              res.word_c = w2_new;
            end else if (cur.phase == mcsp_pkg::PH_FACE) begin
              // The fourth 16-bit word carries the face flags and is dropped.
              res.kind   = mcsp_pkg::KIND_FACE;
              res.word_a = {16'd0, w0_new[15:0]};
              res.word_b = {16'd0, w0_new[31:16]};
              res.word_c = {16'd0, w1_new[15:0]};
            end else begin
              res.kind   = mcsp_pkg::KIND_MAP;
              res.word_a = w0_new;
              res.word_b = w1_new;
            end
            if (cur.phase == mcsp_pkg::PH_VERTEX && (bad_x || bad_y || bad_z)) begin
              nxt.halted = 1'b1;
            end else begin
              nxt.elem_idx  = idx_inc;
              nxt.elem_byte = 4'd0;
              nxt.word0     = 32'd0;
              nxt.word1     = 32'd0;
              nxt.word2     = 32'd0;
              if (idx_inc >= cur.elem_total) begin
                nxt.phase = mcsp_pkg::PH_HEADER;
              end
            end
          end
        end

        mcsp_pkg::PH_SKIP: begin
          nxt.skip_left = skip_dec;
          if (skip_dec == 32'd0) begin
            nxt.phase = mcsp_pkg::PH_HEADER;
          end
        end

        default: begin
          nxt.phase   = mcsp_pkg::PH_HEADER;
          nxt.hdr_cnt = 3'd0;
        end
      endcase
    end
  end

endmodule
